FILE: sv/stm_pkg.sv
// Package of the SAD template matcher: sizes, field widths, codes and the
// shared types. Depends on nothing; all but the two interfaces import it.
package stm_pkg;

   localparam int TEMPLATE_H = 8;
   localparam int TEMPLATE_W = 8;
   localparam int MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int LINES = TEMPLATE_H - 1;
   localparam int TAPS = TEMPLATE_H * TEMPLATE_W;
   localparam int TAP_W = $clog2(TAPS);
   localparam int SAMPLE_W = 16;
   localparam int LS_W = LINES * SAMPLE_W;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = 13;
   localparam int WROW_W = 12;
   localparam int CFG_W = 13;
   localparam int WIDTH_W = 11;
   localparam int SHIFT_W = $clog2(TEMPLATE_W);
   localparam int ABS_W = SAMPLE_W;
   localparam int ROWSUM_W = ABS_W + $clog2(TEMPLATE_W);
   localparam int TOTAL_W = ROWSUM_W + $clog2(TEMPLATE_H);
   localparam int SAD_W = 22;

   localparam logic [1:0] MODE_TEMPLATE = 2'd0;
   localparam logic [1:0] MODE_PIXEL = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   localparam logic CSR_IMAGE_WIDTH = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [TEMPLATE_H-1:0][TEMPLATE_W-1:0][SAMPLE_W-1:0] window_type;
   typedef logic [TAPS-1:0][SAMPLE_W-1:0] tmpl_type;

   typedef struct packed {
      logic valid;
      window_type window;
      logic [SHIFT_W-1:0] shift;
      logic [SHIFT_W-1:0] count;
      logic [COL_W-1:0] col;
      logic [WROW_W-1:0] row;
   } job_type;

   typedef struct packed {
      logic valid;
      logic [SAD_W-1:0] sad;
      logic [WROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic last;
   } result_type;

endpackage

FILE: sv/stm_req_if.sv
// Input channel of the SAD template matcher: valid, ready and one item.
// Stands alone; field widths follow the item format.
interface stm_req_if;
   logic valid;
   logic ready;
   logic [1:0] mode;
   logic [5:0] tap_index;
   logic signed [15:0] value;

   modport source (output valid, output mode, output tap_index, output value, input ready);
   modport sink (input valid, input mode, input tap_index, input value, output ready);
endinterface

FILE: sv/stm_rsp_if.sv
// Result channel of the SAD template matcher: valid, ready and one result.
// Stands alone; field widths follow the result format.
interface stm_rsp_if;
   logic valid;
   logic ready;
   logic [21:0] sad;
   logic [11:0] win_row;
   logic [9:0] win_col;
   logic last;

   modport source (output valid, output sad, output win_row, output win_col, output last,
                   input ready);
   modport sink (input valid, input sad, input win_row, input win_col, input last,
                 output ready);
endinterface

FILE: sv/stm_line_store.sv
// Line store: one memory row per image column holding the previous rows.
// Clears itself after reset and forwards a write that meets a read. Uses stm_pkg.
module stm_line_store (
   input  logic clock,
   input  logic reset,
   input  logic rd_en,
   input  logic [stm_pkg::COL_W-1:0] rd_addr,
   input  logic wr_en,
   input  logic [stm_pkg::COL_W-1:0] wr_addr,
   input  logic [stm_pkg::LS_W-1:0] wr_data,
   output logic [stm_pkg::LS_W-1:0] rd_data,
   output logic clear_busy
);
   import stm_pkg::*;

   logic [LS_W-1:0] mem [MAX_WIDTH];
   logic [LS_W-1:0] rd_ff;
   logic fwd_ff;
   logic [LS_W-1:0] fwd_data_ff;
   logic clr_busy_ff;
   logic [COL_W-1:0] clr_ff;

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
         fwd_ff <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : rd_ff;
   assign clear_busy = clr_busy_ff;

endmodule

FILE: sv/stm_sad_engine.sv
// SAD engine: holds one window job and, unless a held result stalls it, issues its
// windows one per cycle into a registered difference and adder tree. Uses stm_pkg.
module stm_sad_engine (
   input  logic clock,
   input  logic reset,
   input  stm_pkg::job_type job,
   input  stm_pkg::tmpl_type tmpl,
   input  logic out_ready,
   output logic slot_ready,
   output logic busy,
   output stm_pkg::result_type result
);
   import stm_pkg::*;

   logic busy_ff;
   window_type snap_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [SHIFT_W-1:0] rem_ff;
   logic [COL_W-1:0] col_ff;
   logic [WROW_W-1:0] row_ff;

   logic a_valid_ff, b_valid_ff, c_valid_ff;
   logic [TEMPLATE_H-1:0][TEMPLATE_W-1:0][ABS_W-1:0] absd_ff;
   logic [TEMPLATE_H-1:0][ROWSUM_W-1:0] rsum_ff;
   logic [SAD_W-1:0] sad_ff;
   logic [COL_W-1:0] a_col_ff, b_col_ff, c_col_ff;
   logic [WROW_W-1:0] a_row_ff, b_row_ff, c_row_ff;
   logic a_last_ff, b_last_ff, c_last_ff;

   logic adv, issue, load;
   logic [TEMPLATE_H-1:0][TEMPLATE_W-1:0][ABS_W-1:0] absd_in;
   logic [TEMPLATE_H-1:0][ROWSUM_W-1:0] rsum_in;
   logic [TOTAL_W-1:0] total_in;

   assign adv = !c_valid_ff || out_ready;
   assign issue = busy_ff && adv;
   assign slot_ready = !busy_ff || (issue && rem_ff == '0);
   assign load = job.valid && slot_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (issue && rem_ff == '0) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         snap_ff <= job.window;
         shift_ff <= job.shift;
         rem_ff <= job.count;
         col_ff <= job.col;
         row_ff <= job.row;
      end else if (issue) begin
         shift_ff <= shift_ff + 1'b1;
         rem_ff <= rem_ff - 1'b1;
         col_ff <= col_ff + 1'b1;
      end
   end

   always_comb begin
      logic [SAMPLE_W-1:0] px;
      logic signed [SAMPLE_W:0] d;
      for (int m = 0; m < TEMPLATE_H; m++) begin
         for (int n = 0; n < TEMPLATE_W; n++) begin
            px = '0;
            for (int k = 0; k < TEMPLATE_W; k++) begin
               if (k >= n && (SHIFT_W+1)'(k - n) == {1'b0, shift_ff}) begin
                  px = snap_ff[m][k];
               end
            end
            d = $signed({px[SAMPLE_W-1], px})
                - $signed({tmpl[m*TEMPLATE_W+n][SAMPLE_W-1], tmpl[m*TEMPLATE_W+n]});
            absd_in[m][n] = d[SAMPLE_W] ? ABS_W'(-d) : ABS_W'(d);
         end
      end
   end

   always_comb begin
      for (int m = 0; m < TEMPLATE_H; m++) begin
         rsum_in[m] = '0;
         for (int n = 0; n < TEMPLATE_W; n++) begin
            rsum_in[m] = rsum_in[m] + ROWSUM_W'(absd_ff[m][n]);
         end
      end
      total_in = '0;
      for (int m = 0; m < TEMPLATE_H; m++) begin
         total_in = total_in + TOTAL_W'(rsum_ff[m]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= issue;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         absd_ff <= absd_in;
         a_col_ff <= col_ff;
         a_row_ff <= row_ff;
         a_last_ff <= rem_ff == '0;
         rsum_ff <= rsum_in;
         b_col_ff <= a_col_ff;
         b_row_ff <= a_row_ff;
         b_last_ff <= a_last_ff;
         sad_ff <= SAD_W'(total_in);
         c_col_ff <= b_col_ff;
         c_row_ff <= b_row_ff;
         c_last_ff <= b_last_ff;
      end
   end

   assign busy = busy_ff;
   assign result.valid = c_valid_ff;
   assign result.sad = sad_ff;
   assign result.row = c_row_ff;
   assign result.col = c_col_ff;
   assign result.last = c_last_ff;

endmodule

FILE: sv/sad_template_match.sv
// Top level of the SAD template matcher: counters, template, window and
// the line store read-modify-write stage. Uses stm_pkg, the channel
// interfaces, stm_line_store and stm_sad_engine.
//
// An 8x8 signed template is written with mode 0 beats, then pixels and flush
// ticks stream in raster order at one beat per clock. Each pixel reads its
// column's line store row when accepted; the write-back stage then shifts the
// window and writes the row back, forwarding when consecutive beats hit the
// same column. A beat that completes windows hands them to the SAD engine,
// which issues one window per cycle into a three-stage difference and adder
// tree that registers the absolute differences, the row sums and the total in
// turn. With the result channel ready, beats sustain one per cycle, row ends
// included: a row end hands over up to eight windows, and the engine has
// issued them by the time the next window-producing beat reaches it. A held
// result stalls the tree, and a window-producing beat then waits in the
// write-back stage and holds off the input. A template write waits until the
// engine holds no job and the write-back stage is empty. After reset the line
// store clears all 1024 rows, during which no beat is accepted; register
// writes are taken at any time.
module sad_template_match (
   input  logic clock,
   input  logic reset,
   stm_req_if.sink req_bus,
   stm_rsp_if.source rsp_bus,
   input  logic csr_write_enable,
   input  logic csr_index,
   input  logic [12:0] csr_write_data
);
   import stm_pkg::*;

   logic [WIDTH_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   sample_type [TAPS-1:0] tmpl_ff;
   window_type win_ff;

   logic p1_valid_ff;
   sample_type p1_pixel_ff;
   logic [COL_W-1:0] p1_addr_ff;
   logic p1_emit_ff;
   logic [SHIFT_W-1:0] p1_shift_ff;
   logic [SHIFT_W-1:0] p1_count_ff;
   logic [COL_W-1:0] p1_lo_ff;
   logic [WROW_W-1:0] p1_row_ff;

   logic [COL_W-1:0] wm1, cur_col, lo_in;
   logic [CFG_W-1:0] h_eff;
   logic [ROW_W-1:0] row_nx;
   logic row_end, emit_in, accept, accept_px, p1_done, clear_busy;
   logic [SHIFT_W-1:0] shift_in, count_in;
   sample_type pixel_in;
   logic [LS_W-1:0] ls_old, ls_new;
   window_type win_in;
   job_type job;
   result_type result;
   logic slot_ready, engine_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_W'(1000);
         height_ff <= CFG_W'(1000);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: width_ff <= csr_write_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         wm1 = '0;
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         wm1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         wm1 = COL_W'(width_ff - 1'b1);
      end
      if (height_ff == '0) begin
         h_eff = CFG_W'(1);
      end else if (height_ff > CFG_W'(MAX_HEIGHT)) begin
         h_eff = CFG_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      cur_col = (col_ff > wm1) ? wm1 : col_ff;
      row_end = cur_col == wm1;
      pixel_in = (req_bus.mode == MODE_PIXEL && row_ff < h_eff) ? req_bus.value : '0;
      emit_in = row_ff >= ROW_W'(LINES)
                && {1'b0, row_ff} < ({1'b0, h_eff} + (CFG_W+1)'(LINES))
                && (row_end || cur_col >= COL_W'(TEMPLATE_W - 1));
      if (!row_end) begin
         lo_in = cur_col - COL_W'(TEMPLATE_W - 1);
         count_in = '0;
         shift_in = '0;
      end else if (cur_col >= COL_W'(TEMPLATE_W - 1)) begin
         lo_in = cur_col - COL_W'(TEMPLATE_W - 1);
         count_in = SHIFT_W'(TEMPLATE_W - 1);
         shift_in = '0;
      end else begin
         lo_in = '0;
         count_in = SHIFT_W'(cur_col);
         shift_in = SHIFT_W'(TEMPLATE_W - 1) - SHIFT_W'(cur_col);
      end
      row_nx = row_ff + 1'b1;
   end

   assign p1_done = p1_valid_ff && (!p1_emit_ff || slot_ready);
   assign req_bus.ready = !clear_busy && (!p1_valid_ff || p1_done)
                          && !(req_bus.mode == MODE_TEMPLATE && (p1_valid_ff || engine_busy));
   assign accept = req_bus.valid && req_bus.ready;
   assign accept_px = accept && (req_bus.mode == MODE_PIXEL || req_bus.mode == MODE_FLUSH);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept_px) begin
         if (row_end) begin
            col_ff <= '0;
            if ({1'b0, row_nx} >= ({1'b0, h_eff} + (CFG_W+1)'(LINES))) begin
               row_ff <= '0;
            end else begin
               row_ff <= row_nx;
            end
         end else begin
            col_ff <= cur_col + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmpl_ff <= '0;
      end else if (accept && req_bus.mode == MODE_TEMPLATE
                   && (TAP_W+1)'(req_bus.tap_index) < (TAP_W+1)'(TAPS)) begin
         tmpl_ff[req_bus.tap_index[TAP_W-1:0]] <= req_bus.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (accept_px) begin
         p1_valid_ff <= 1'b1;
      end else if (p1_done) begin
         p1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_px) begin
         p1_pixel_ff <= pixel_in;
         p1_addr_ff <= cur_col;
         p1_emit_ff <= emit_in;
         p1_shift_ff <= shift_in;
         p1_count_ff <= count_in;
         p1_lo_ff <= lo_in;
         p1_row_ff <= WROW_W'(row_ff - ROW_W'(LINES));
      end
   end

   stm_line_store u_line_store (
      .clock(clock),
      .reset(reset),
      .rd_en(accept_px),
      .rd_addr(cur_col),
      .wr_en(p1_done),
      .wr_addr(p1_addr_ff),
      .wr_data(ls_new),
      .rd_data(ls_old),
      .clear_busy(clear_busy)
   );

   always_comb begin
      ls_new = LS_W'({ls_old, p1_pixel_ff});
      for (int m = 0; m < TEMPLATE_H; m++) begin
         for (int t = 0; t < TEMPLATE_W - 1; t++) begin
            win_in[m][t] = win_ff[m][t+1];
         end
         if (m < LINES) begin
            win_in[m][TEMPLATE_W-1] = ls_old[(LINES-1-m)*SAMPLE_W +: SAMPLE_W];
         end else begin
            win_in[m][TEMPLATE_W-1] = p1_pixel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (p1_done) begin
         win_ff <= win_in;
      end
   end

   assign job.valid = p1_valid_ff && p1_emit_ff;
   assign job.window = win_in;
   assign job.shift = p1_shift_ff;
   assign job.count = p1_count_ff;
   assign job.col = p1_lo_ff;
   assign job.row = p1_row_ff;

   stm_sad_engine u_sad_engine (
      .clock(clock),
      .reset(reset),
      .job(job),
      .tmpl(tmpl_ff),
      .out_ready(rsp_bus.ready),
      .slot_ready(slot_ready),
      .busy(engine_busy),
      .result(result)
   );

   assign rsp_bus.valid = result.valid;
   assign rsp_bus.sad = result.sad;
   assign rsp_bus.win_row = result.row;
   assign rsp_bus.win_col = result.col;
   assign rsp_bus.last = result.last;

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_bus.ready)
      else $error("beat accepted during line store clear");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (p1_valid_ff && !p1_done) |-> !req_bus.ready)
      else $error("beat accepted while the write-back stage is stalled");

   a_tmpl_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.mode == MODE_TEMPLATE) |-> (!engine_busy && !p1_valid_ff))
      else $error("template written while windows are in flight");

   a_job_wait: assert property (@(posedge clock) disable iff (reset)
      (job.valid && !slot_ready) |=> p1_valid_ff)
      else $error("window job dropped while the engine was busy");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench of the SAD template matcher: a directed table, then
// random frames under random idling, all checked against a built-in predictor.
// Depends on stm_pkg, stm_req_if, stm_rsp_if and sad_template_match.
`timescale 1ns / 100ps

module tb_top;
   import stm_pkg::*;

   typedef struct {
      int unsigned sad;
      int unsigned row;
      int unsigned col;
      bit last;
   } window_sum_t;

   typedef struct {
      logic [1:0] mode;
      logic [5:0] tap;
      logic signed [15:0] value;
      bit typed;
      int unsigned sad;
   } stim_row_t;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_AFTER = 11;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_IMAGE_WIDTH;
   logic [12:0] csr_write_data = '0;

   stm_req_if req_bus();
   stm_rsp_if rsp_bus();

   sad_template_match DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   window_sum_t sums_due[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int send_idle_pct = 33;
   int recv_idle_pct = 53;
   int cycles = 0;

   // Shadow state of the matcher.
   int tmpl_words[TAPS];
   int line_rows[MAX_WIDTH][LINES];
   int win_px[TEMPLATE_H][TEMPLATE_W];
   int unsigned row_ctr, col_ctr, width_cfg, height_cfg;

   function automatic int unsigned window_sum(int unsigned j, int unsigned c);
      int unsigned sum;
      int unsigned x;
      int d;
      sum = 0;
      for (int m = 0; m < TEMPLATE_H; m++) begin
         for (int n = 0; n < TEMPLATE_W; n++) begin
            x = j + n;
            if (x > c) begin
               d = -tmpl_words[m*TEMPLATE_W+n];
            end else begin
               d = win_px[m][x+TEMPLATE_W-1-c] - tmpl_words[m*TEMPLATE_W+n];
            end
            sum += (d < 0) ? -d : d;
         end
      end
      return sum;
   endfunction

   function automatic void predict_beat(logic [1:0] mode, logic [5:0] tap,
                                        logic signed [15:0] value);
      int unsigned w, h, c, r, lo, hi;
      int px;
      int column[TEMPLATE_H];
      bit emit;
      window_sum_t e;
      emit = 0;
      lo = 0;
      hi = 0;
      if (mode == MODE_TEMPLATE) begin
         tmpl_words[tap] = int'(value);
         return;
      end
      if (mode == MODE_UNUSED) return;
      w = (width_cfg == 0) ? 1 : (width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg;
      h = (height_cfg == 0) ? 1 : (height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : height_cfg;
      c = (col_ctr >= w) ? w - 1 : col_ctr;
      r = row_ctr;
      px = (mode == MODE_PIXEL && r < h) ? int'(value) : 0;
      for (int m = 0; m < LINES; m++) column[m] = line_rows[c][LINES-1-m];
      column[TEMPLATE_H-1] = px;
      for (int k = LINES - 1; k > 0; k--) line_rows[c][k] = line_rows[c][k-1];
      line_rows[c][0] = px;
      for (int m = 0; m < TEMPLATE_H; m++) begin
         for (int t = 0; t < TEMPLATE_W - 1; t++) win_px[m][t] = win_px[m][t+1];
         win_px[m][TEMPLATE_W-1] = column[m];
      end
      if (r >= LINES && r - LINES < h) begin
         if (c == w - 1) begin
            lo = (c >= TEMPLATE_W - 1) ? c - (TEMPLATE_W - 1) : 0;
            hi = c;
            emit = 1;
         end else if (c >= TEMPLATE_W - 1) begin
            lo = c - (TEMPLATE_W - 1);
            hi = lo;
            emit = 1;
         end
      end
      if (emit) begin
         for (int unsigned j = lo; j <= hi; j++) begin
            e.sad = window_sum(j, c) & 22'h3FFFFF;
            e.row = (r - LINES) & 12'hFFF;
            e.col = j & 10'h3FF;
            e.last = (j == hi);
            sums_due.push_back(e);
         end
      end
      if (c == w - 1) begin
         col_ctr = 0;
         row_ctr = r + 1;
         if (row_ctr >= h + LINES) row_ctr = 0;
      end else begin
         col_ctr = c + 1;
      end
   endfunction

   task automatic send_beat(logic [1:0] mode, logic [5:0] tap, logic signed [15:0] value);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.tap_index <= tap;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      predict_beat(mode, tap, value);
      if (mode != MODE_UNUSED) items_sent++;
      if (items_sent > 200) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end else if (items_sent > 100) begin
         send_idle_pct = 53;
         recv_idle_pct = 33;
      end
   endtask

   task automatic write_csr(logic index, logic [12:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_IMAGE_WIDTH) width_cfg = 32'(data & 13'h7FF);
      else height_cfg = 32'(data);
   endtask

   task automatic settle_and_configure(int unsigned w, int unsigned h);
      req_bus.valid <= 1'b0;
      wait (sums_due.size() == 0);
      repeat (40) @(posedge clock);
      write_csr(CSR_IMAGE_WIDTH, 13'(w));
      write_csr(CSR_IMAGE_HEIGHT, 13'(h));
   endtask

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(int unsigned w, int unsigned h, int unsigned pixels);
      int unsigned pick;
      settle_and_configure(w, h);
      for (int unsigned i = 0; i < pixels; i++) begin
         pick = $urandom_range(99);
         if (pick < 4) send_beat(MODE_TEMPLATE, 6'($urandom), random_sample());
         else if (pick < 7) send_beat(MODE_UNUSED, 6'($urandom), 16'($urandom));
         if (pick >= 95 && i > 0) send_beat(MODE_FLUSH, 6'($urandom), 16'($urandom));
         else send_beat(MODE_PIXEL, 6'($urandom), random_sample());
      end
   endtask

   stim_row_t directed[$] = '{
      '{MODE_PIXEL, 6'd0, 16'sh8000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh1234, 0, 0},
      '{MODE_FLUSH, 6'd63, 16'sh7FFF, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh8000, 1, 32768},
      '{MODE_TEMPLATE, 6'd0, 16'sh7FFF, 0, 0},
      '{MODE_TEMPLATE, 6'd63, 16'sh8000, 0, 0},
      '{MODE_TEMPLATE, 6'd9, 16'sh04D2, 0, 0},
      '{MODE_UNUSED, 6'd63, 16'shFFFF, 0, 0},
      '{MODE_PIXEL, 6'd21, 16'sh7FFF, 0, 0},
      '{MODE_PIXEL, 6'd0, 16'sh8000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0},
      '{MODE_FLUSH, 6'd0, 16'sh0000, 0, 0}
   };

   int unsigned phase_width[8] = '{3, 1, 0, 9, 2047, 5, 2, 4};
   int unsigned phase_height[8] = '{2, 2, 0, 2, 8191, 1, 1, 1};

   initial begin
      int unsigned p;
      int unsigned w, h;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_TEMPLATE;
      req_bus.tap_index = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      foreach (tmpl_words[i]) tmpl_words[i] = 0;
      foreach (line_rows[i, k]) line_rows[i][k] = 0;
      foreach (win_px[m, n]) win_px[m][n] = 0;
      row_ctr = 0;
      col_ctr = 0;
      width_cfg = 1000;
      height_cfg = 1000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The first frame uses a single-pixel image with an all-zero template.
      write_csr(CSR_IMAGE_WIDTH, 13'd1);
      write_csr(CSR_IMAGE_HEIGHT, 13'd1);
      foreach (directed[i]) begin
         send_beat(directed[i].mode, directed[i].tap, directed[i].value);
         if (directed[i].typed) sums_due[$].sad = directed[i].sad;
      end
      for (int t = 0; t < TAPS; t++) send_beat(MODE_TEMPLATE, 6'(t), random_sample());
      p = 0;
      while (p < 8) begin
         w = phase_width[p];
         h = phase_height[p];
         if (w > MAX_WIDTH) run_phase(w, h, 20);
         else run_phase(w, h, ((w == 0) ? 1 : w) * (((h == 0) ? 1 : h) + LINES));
         p++;
      end
      req_bus.valid <= 1'b0;
      wait (sums_due.size() == 0);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Receiver with random stalls and one long hold-off to back up the block.
   initial begin
      @(negedge reset);
      forever begin
         if (results_seen == HOLD_AFTER) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            results_seen++;
         end
         rsp_bus.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      window_sum_t e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (results_seen != HOLD_AFTER) results_seen <= results_seen + 1;
         if (sums_due.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: sad %0d row %0d col %0d last %0b", $time,
                     rsp_bus.sad, rsp_bus.win_row, rsp_bus.win_col, rsp_bus.last);
         end else begin
            e = sums_due.pop_front();
            if (rsp_bus.sad !== e.sad[21:0] || rsp_bus.win_row !== e.row[11:0] ||
                rsp_bus.win_col !== e.col[9:0] || rsp_bus.last !== e.last) begin
               errors++;
               $display("%0t mismatch: expected sad %0d row %0d col %0d last %0b",
                        $time, e.sad, e.row, e.col, e.last);
               $display("%0t mismatch: actual sad %0d row %0d col %0d last %0b",
                        $time, rsp_bus.sad, rsp_bus.win_row, rsp_bus.win_col,
                        rsp_bus.last);
            end
         end
      end
   end

endmodule
